FILE: hw/rtl/dtdm_pkg.sv
// Shared widths, constants, types and the month offset table for the date-time difference block.
`timescale 1ns / 1ps

package dtdm_pkg;

    localparam int YEAR_W    = 12;
    localparam int MONTH_W   = 4;
    localparam int DAY_W     = 5;
    localparam int HOUR_W    = 5;
    localparam int MINUTE_W  = 6;
    localparam int DAYNUM_W  = 21;
    localparam int DAYDIFF_W = DAYNUM_W + 1;
    localparam int OFFSET_W  = 9;
    localparam int ELAPSED_W = 28;
    localparam int TOTAL_W   = 35;

    // Reciprocal of 100 scaled by 2**19; exact for every 12-bit value.
    localparam int RECIP_W     = 13;
    localparam int RECIP_SHIFT = 19;
    localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;

    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    localparam logic [8:0]  DAYS_PER_YEAR  = 9'd365;
    localparam logic [6:0]  YEARS_PER_CENT = 7'd100;
    localparam logic [10:0] MIN_PER_DAY    = 11'd1440;
    localparam logic [5:0]  MIN_PER_HOUR   = 6'd60;

    typedef struct packed {
        logic [DAYNUM_W-1:0]   end_days;
        logic [DAYNUM_W-1:0]   start_days;
        logic signed [HOUR_W:0]   hour_diff;
        logic signed [MINUTE_W:0] minute_diff;
        logic                  month_error;
    } day_stage_t;

    // Days in the year before the first of the given month; unused codes give zero.
    function automatic logic [OFFSET_W-1:0] month_offset(input logic [MONTH_W-1:0] month);
        logic [OFFSET_W-1:0] offset;
        begin
            case (month)
                4'd2:    offset = 9'd31;
                4'd3:    offset = 9'd59;
                4'd4:    offset = 9'd90;
                4'd5:    offset = 9'd120;
                4'd6:    offset = 9'd151;
                4'd7:    offset = 9'd181;
                4'd8:    offset = 9'd212;
                4'd9:    offset = 9'd243;
                4'd10:   offset = 9'd273;
                4'd11:   offset = 9'd304;
                4'd12:   offset = 9'd334;
                default: offset = 9'd0;
            endcase
            return offset;
        end
    endfunction

endpackage

FILE: hw/rtl/dtdm_day_number.sv
// Absolute Gregorian day number of one date, with a flag for an invalid month.
`timescale 1ns / 1ps

module dtdm_day_number (
    input  logic [dtdm_pkg::YEAR_W-1:0]   year,
    input  logic [dtdm_pkg::MONTH_W-1:0]  month,
    input  logic [dtdm_pkg::DAY_W-1:0]    day,
    output logic [dtdm_pkg::DAYNUM_W-1:0] day_num,
    output logic                          month_bad
);

    localparam int PROD_W = dtdm_pkg::YEAR_W + dtdm_pkg::RECIP_W;
    localparam int CENT_W = PROD_W - dtdm_pkg::RECIP_SHIFT;

    logic [dtdm_pkg::YEAR_W-1:0]   prev_year;
    logic [PROD_W-1:0]             prev_prod;
    logic [PROD_W-1:0]             year_prod;
    logic [CENT_W-1:0]             prev_div100;
    logic [CENT_W-1:0]             year_div100;
    logic [CENT_W+6:0]             year_cent_base;
    logic                          year_is_cent;
    logic                          leap;
    logic [dtdm_pkg::DAYNUM_W-1:0] years_before;
    logic [dtdm_pkg::DAYNUM_W-1:0] year_days;

    assign prev_year = year - dtdm_pkg::YEAR_W'(1);

    // Division by 100 as a multiply by a scaled reciprocal.
    assign prev_prod   = PROD_W'(prev_year) * PROD_W'(dtdm_pkg::RECIP_100);
    assign year_prod   = PROD_W'(year) * PROD_W'(dtdm_pkg::RECIP_100);
    assign prev_div100 = prev_prod[PROD_W-1:dtdm_pkg::RECIP_SHIFT];
    assign year_div100 = year_prod[PROD_W-1:dtdm_pkg::RECIP_SHIFT];

    assign year_cent_base = (CENT_W+7)'(year_div100) * (CENT_W+7)'(dtdm_pkg::YEARS_PER_CENT);
    assign year_is_cent   = ((CENT_W+7)'(year) == year_cent_base);

    // Century years are leap only when the century count is a multiple of four.
    assign leap = year_is_cent ? (year_div100[1:0] == 2'd0) : (year[1:0] == 2'd0);

    assign year_days = dtdm_pkg::DAYNUM_W'(year) * dtdm_pkg::DAYNUM_W'(dtdm_pkg::DAYS_PER_YEAR);

    always_comb
    begin
        if (year == '0)
        begin
            years_before = '0;
        end
        else
        begin
            years_before = year_days
                         + dtdm_pkg::DAYNUM_W'(prev_year[dtdm_pkg::YEAR_W-1:2])
                         - dtdm_pkg::DAYNUM_W'(prev_div100)
                         + dtdm_pkg::DAYNUM_W'(prev_div100[CENT_W-1:2])
                         + dtdm_pkg::DAYNUM_W'(1);
        end
    end

    assign day_num = years_before
                   + dtdm_pkg::DAYNUM_W'(dtdm_pkg::month_offset(month))
                   + dtdm_pkg::DAYNUM_W'(day)
                   + dtdm_pkg::DAYNUM_W'(leap && (month > dtdm_pkg::MONTH_FEB));

    assign month_bad = (month == '0) || (month > dtdm_pkg::MONTH_DEC);

endmodule

FILE: hw/rtl/dtdm_minutes.sv
// Converts the day, hour and minute differences to total minutes and saturates to the output width.
`timescale 1ns / 1ps

module dtdm_minutes (
    input  dtdm_pkg::day_stage_t                 stage,
    output logic signed [dtdm_pkg::ELAPSED_W-1:0] elapsed
);

    localparam int TW = dtdm_pkg::TOTAL_W;
    localparam int EW = dtdm_pkg::ELAPSED_W;

    logic signed [dtdm_pkg::DAYDIFF_W-1:0] days_delta;
    logic signed [TW-1:0] day_min;
    logic signed [TW-1:0] hour_min;
    logic signed [TW-1:0] total;
    logic                 in_range;

    assign days_delta = $signed({1'b0, stage.end_days}) - $signed({1'b0, stage.start_days});

    assign day_min  = TW'(days_delta) * $signed(TW'(dtdm_pkg::MIN_PER_DAY));
    assign hour_min = TW'(stage.hour_diff) * $signed(TW'(dtdm_pkg::MIN_PER_HOUR));
    assign total    = day_min + hour_min + TW'(stage.minute_diff);

    // The value fits when all bits above the output sign bit match it.
    assign in_range = (total[TW-1:EW-1] == '0) || (total[TW-1:EW-1] == '1);

    always_comb
    begin
        if (in_range)
        begin
            elapsed = total[EW-1:0];
        end
        else if (total[TW-1])
        begin
            elapsed = {1'b1, {(EW-1){1'b0}}};
        end
        else
        begin
            elapsed = {1'b0, {(EW-1){1'b1}}};
        end
    end

endmodule

FILE: hw/rtl/datetime_difference_minutes.sv
// Top level: three-stage pipeline giving signed minutes between two Gregorian date-times.
`timescale 1ns / 1ps

// A result reaches the output after passing the input register, the day-number register
// and the result register, and a new transaction may be accepted in every cycle while
// in_stall is low: each of these registers holds one transaction, and a stage that has
// been emptied downstream refills in the same cycle. The difference saturates at the
// 28-bit signed limits, and month_error flags a month outside 1 to 12 in either date.
module datetime_difference_minutes (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [dtdm_pkg::YEAR_W-1:0]          start_year,
    input  logic [dtdm_pkg::MONTH_W-1:0]         start_month,
    input  logic [dtdm_pkg::DAY_W-1:0]           start_day,
    input  logic [dtdm_pkg::HOUR_W-1:0]          start_hour,
    input  logic [dtdm_pkg::MINUTE_W-1:0]        start_minute,
    input  logic [dtdm_pkg::YEAR_W-1:0]          end_year,
    input  logic [dtdm_pkg::MONTH_W-1:0]         end_month,
    input  logic [dtdm_pkg::DAY_W-1:0]           end_day,
    input  logic [dtdm_pkg::HOUR_W-1:0]          end_hour,
    input  logic [dtdm_pkg::MINUTE_W-1:0]        end_minute,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [dtdm_pkg::ELAPSED_W-1:0] elapsed_minutes,
    output logic                                 month_error
);

    logic in_valid_reg;
    logic in_valid_next;
    logic day_valid_reg;
    logic day_valid_next;
    logic out_valid_reg;
    logic out_valid_next;

    logic [dtdm_pkg::YEAR_W-1:0]   s_year_reg;
    logic [dtdm_pkg::MONTH_W-1:0]  s_month_reg;
    logic [dtdm_pkg::DAY_W-1:0]    s_day_reg;
    logic [dtdm_pkg::HOUR_W-1:0]   s_hour_reg;
    logic [dtdm_pkg::MINUTE_W-1:0] s_minute_reg;
    logic [dtdm_pkg::YEAR_W-1:0]   e_year_reg;
    logic [dtdm_pkg::MONTH_W-1:0]  e_month_reg;
    logic [dtdm_pkg::DAY_W-1:0]    e_day_reg;
    logic [dtdm_pkg::HOUR_W-1:0]   e_hour_reg;
    logic [dtdm_pkg::MINUTE_W-1:0] e_minute_reg;

    dtdm_pkg::day_stage_t day_stage_next;
    dtdm_pkg::day_stage_t day_stage_reg;

    logic signed [dtdm_pkg::ELAPSED_W-1:0] elapsed_next;
    logic signed [dtdm_pkg::ELAPSED_W-1:0] elapsed_reg;
    logic                                  month_error_reg;

    logic [dtdm_pkg::DAYNUM_W-1:0] start_days;
    logic [dtdm_pkg::DAYNUM_W-1:0] end_days;
    logic start_bad;
    logic end_bad;

    logic out_load;
    logic day_load;
    logic in_load;

    // Each stage takes a new transaction when it is empty or its content moves on.
    assign out_load = !out_valid_reg || !out_stall;
    assign day_load = !day_valid_reg || out_load;
    assign in_load  = !in_valid_reg || day_load;
    assign in_stall = !in_load;

    always_comb
    begin
        in_valid_next  = in_load  ? in_valid      : in_valid_reg;
        day_valid_next = day_load ? in_valid_reg  : day_valid_reg;
        out_valid_next = out_load ? day_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            day_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            day_valid_reg <= day_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load && in_valid)
        begin
            s_year_reg   <= start_year;
            s_month_reg  <= start_month;
            s_day_reg    <= start_day;
            s_hour_reg   <= start_hour;
            s_minute_reg <= start_minute;
            e_year_reg   <= end_year;
            e_month_reg  <= end_month;
            e_day_reg    <= end_day;
            e_hour_reg   <= end_hour;
            e_minute_reg <= end_minute;
        end
    end

    dtdm_day_number u_start_day (
        .year      (s_year_reg),
        .month     (s_month_reg),
        .day       (s_day_reg),
        .day_num   (start_days),
        .month_bad (start_bad)
    );

    dtdm_day_number u_end_day (
        .year      (e_year_reg),
        .month     (e_month_reg),
        .day       (e_day_reg),
        .day_num   (end_days),
        .month_bad (end_bad)
    );

    always_comb
    begin
        day_stage_next.end_days    = end_days;
        day_stage_next.start_days  = start_days;
        day_stage_next.hour_diff   = $signed({1'b0, e_hour_reg}) - $signed({1'b0, s_hour_reg});
        day_stage_next.minute_diff = $signed({1'b0, e_minute_reg})
                                   - $signed({1'b0, s_minute_reg});
        day_stage_next.month_error = start_bad || end_bad;
    end

    always_ff @(posedge clk)
    begin
        if (day_load && in_valid_reg)
        begin
            day_stage_reg <= day_stage_next;
        end
    end

    dtdm_minutes u_minutes (
        .stage   (day_stage_reg),
        .elapsed (elapsed_next)
    );

    always_ff @(posedge clk)
    begin
        if (out_load && day_valid_reg)
        begin
            elapsed_reg     <= elapsed_next;
            month_error_reg <= day_stage_reg.month_error;
        end
    end

    assign out_valid       = out_valid_reg;
    assign elapsed_minutes = elapsed_reg;
    assign month_error     = month_error_reg;

endmodule
